>>> hw/rtl/lsb_stego_bmp_extractor_core_defines.svh
// Assertion macros shared by the extractor RTL.
`ifndef LSB_STEGO_BMP_EXTRACTOR_CORE_DEFINES_SVH
`define LSB_STEGO_BMP_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LSBX_ASSERT_ALWAYS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsbx: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LSBX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsbx: next-cycle check failed");

`endif

>>> hw/rtl/lsbx_pkg.sv
// Types and constants of the LSB stego BMP extractor.
package lsbx_pkg;

   localparam int HEADER_BYTES    = 54;
   localparam int MAGIC_MAX       = 8;
   localparam int CHAR_BITS       = 8;
   localparam int LENGTH_BITS     = 32;
   localparam int REMAIN_W        = 31;
   localparam int COUNT_W         = 6;
   localparam int MAGIC_W         = 64;
   localparam int MAGIC_LEN_W     = 4;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 64;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXT_LEN,
      PH_EXT_DATA,
      PH_PAY_LEN,
      PH_PAY_DATA,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_EXT,
      KIND_PAY,
      KIND_ERR,
      KIND_EMPTY
   } kind_type;

   typedef enum logic {
      CSR_MAGIC_STRING,
      CSR_MAGIC_LENGTH
   } csr_index_type;

   typedef struct packed {
      logic [MAGIC_W-1:0]     magic_string;
      logic [MAGIC_LEN_W-1:0] magic_length;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [CHAR_BITS-1:0] out_byte;
      kind_type             kind;
      logic                 last;
   } res_type;

endpackage

>>> hw/rtl/lsbx_csr.sv
// APB-style configuration registers of the extractor.
module lsbx_csr import lsbx_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [MAGIC_W-1:0]     magic_string_ff, magic_string_in;
   logic [MAGIC_LEN_W-1:0] magic_length_ff, magic_length_in;
   logic                   wr_en;
   csr_index_type          reg_idx;

   // Registers sit on 8-byte boundaries, so address bit 3 picks the register.
   assign reg_idx    = csr_index_type'(csr_paddr[3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      magic_string_in = magic_string_ff;
      magic_length_in = magic_length_ff;
      if (wr_en) begin
         unique case (reg_idx)
            CSR_MAGIC_STRING: magic_string_in = csr_pwdata[MAGIC_W-1:0];
            CSR_MAGIC_LENGTH: magic_length_in = csr_pwdata[MAGIC_LEN_W-1:0];
            default:          magic_string_in = magic_string_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_MAGIC_STRING: csr_prdata = CSR_DATA_W'(magic_string_ff);
         CSR_MAGIC_LENGTH: csr_prdata = CSR_DATA_W'(magic_length_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_string_ff <= '0;
         magic_length_ff <= MAGIC_LEN_W'(1);
      end else begin
         magic_string_ff <= magic_string_in;
         magic_length_ff <= magic_length_in;
      end
   end

   assign cfg.magic_string = magic_string_ff;
   assign cfg.magic_length = magic_length_ff;

endmodule

>>> hw/rtl/lsbx_parser.sv
// Frame parser: header skip, magic check, length fields and byte assembly.
`include "lsb_stego_bmp_extractor_core_defines.svh"
module lsbx_parser import lsbx_pkg::*; #(
   parameter int HDR_BYTES   = HEADER_BYTES,
   parameter int MAGIC_CHARS = MAGIC_MAX
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [CHAR_BITS-1:0] image_byte,
   input  logic                 file_start,
   input  cfg_type              cfg,
   output res_type              res
);

   phase_type               phase_ff, phase_in;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0]  bits_ff, bits_in;
   logic [MAGIC_LEN_W-1:0]  midx_ff, midx_in;
   logic [REMAIN_W-1:0]     rem_ff, rem_in;
   logic                    bad_ff, bad_in;
   logic [MAGIC_LEN_W-1:0]  eff_len;

   assign eff_len = (cfg.magic_length > MAGIC_LEN_W'(MAGIC_CHARS)) ?
                    MAGIC_LEN_W'(MAGIC_CHARS) : cfg.magic_length;

   always_comb begin : parse
      phase_type              p;
      logic [COUNT_W-1:0]     c;
      logic [LENGTH_BITS-1:0] b;
      logic [MAGIC_LEN_W-1:0] mi;
      logic [REMAIN_W-1:0]    r;
      logic                   bad;
      logic                   skip;
      logic                   bit_in;
      logic [CHAR_BITS-1:0]   b8;
      logic [CHAR_BITS-1:0]   want;

      p      = phase_ff;
      c      = cnt_ff;
      b      = bits_ff;
      mi     = midx_ff;
      r      = rem_ff;
      bad    = bad_ff;
      skip   = 1'b0;
      bit_in = image_byte[0];
      res    = '0;

      if (file_start) begin
         p   = PH_HEADER;
         c   = '0;
         b   = '0;
         mi  = '0;
         r   = '0;
         bad = 1'b0;
      end

      // The header counter reuses the byte counter of the data phases.
      if (p == PH_HEADER) begin
         if (r < REMAIN_W'(HDR_BYTES)) begin
            r    = r + 1'b1;
            skip = 1'b1;
         end else begin
            r   = '0;
            c   = '0;
            b   = '0;
            mi  = '0;
            bad = 1'b0;
            p   = (eff_len == '0) ? PH_EXT_LEN : PH_MAGIC;
         end
      end

      b8   = {b[CHAR_BITS-2:0], bit_in};
      want = cfg.magic_string[mi[2:0]*CHAR_BITS +: CHAR_BITS];

      if (!skip) begin
         unique case (p)
            PH_MAGIC: begin
               c = c + 1'b1;
               if (c < COUNT_W'(CHAR_BITS)) begin
                  b = LENGTH_BITS'(b8);
               end else begin
                  if (want != b8) begin
                     bad = 1'b1;
                  end
                  c  = '0;
                  b  = '0;
                  mi = mi + 1'b1;
                  if (mi >= eff_len) begin
                     if (bad) begin
                        p            = PH_IDLE;
                        res.valid    = 1'b1;
                        res.kind     = KIND_ERR;
                        res.last     = 1'b1;
                     end else begin
                        p = PH_EXT_LEN;
                     end
                  end
               end
            end
            PH_EXT_LEN, PH_PAY_LEN: begin
               b = {b[LENGTH_BITS-2:0], bit_in};
               c = c + 1'b1;
               if (c == COUNT_W'(LENGTH_BITS)) begin
                  // A length with the sign bit set counts as zero.
                  r = b[LENGTH_BITS-1] ? '0 : b[REMAIN_W-1:0];
                  c = '0;
                  b = '0;
                  if (p == PH_EXT_LEN) begin
                     p = (r != '0) ? PH_EXT_DATA : PH_PAY_LEN;
                  end else if (r == '0) begin
                     p         = PH_IDLE;
                     res.valid = 1'b1;
                     res.kind  = KIND_EMPTY;
                     res.last  = 1'b1;
                  end else begin
                     p = PH_PAY_DATA;
                  end
               end
            end
            PH_EXT_DATA, PH_PAY_DATA: begin
               c = c + 1'b1;
               if (c < COUNT_W'(CHAR_BITS)) begin
                  b = LENGTH_BITS'(b8);
               end else begin
                  c = '0;
                  b = '0;
                  if (r != '0) begin
                     r = r - 1'b1;
                  end
                  res.valid    = 1'b1;
                  res.out_byte = b8;
                  if (p == PH_EXT_DATA) begin
                     res.kind = KIND_EXT;
                     if (r == '0) begin
                        p = PH_PAY_LEN;
                     end
                  end else begin
                     res.kind = KIND_PAY;
                     if (r == '0) begin
                        p        = PH_IDLE;
                        res.last = 1'b1;
                     end
                  end
               end
            end
            default: begin
               skip = 1'b1;
            end
         endcase
      end

      phase_in = p;
      cnt_in   = c;
      bits_in  = b;
      midx_in  = mi;
      rem_in   = r;
      bad_in   = bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         cnt_ff   <= '0;
         bits_ff  <= '0;
         midx_ff  <= '0;
         rem_ff   <= '0;
         bad_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         bits_ff  <= bits_in;
         midx_ff  <= midx_in;
         rem_ff   <= rem_in;
         bad_ff   <= bad_in;
      end
   end

   `LSBX_ASSERT_ALWAYS(a_data_has_bytes, clock, reset,
      (phase_ff == PH_EXT_DATA) || (phase_ff == PH_PAY_DATA), rem_ff != '0)
   `LSBX_ASSERT_ALWAYS(a_char_count, clock, reset,
      (phase_ff == PH_MAGIC) || (phase_ff == PH_EXT_DATA) || (phase_ff == PH_PAY_DATA),
      cnt_ff < COUNT_W'(CHAR_BITS))
   `LSBX_ASSERT_ALWAYS(a_status_form, clock, reset,
      res.valid && ((res.kind == KIND_ERR) || (res.kind == KIND_EMPTY)),
      res.last && (res.out_byte == '0))

endmodule

>>> hw/rtl/lsb_stego_bmp_extractor_core.sv
// LSB steganography BMP extractor, top level.
//
// Feed a BMP file one byte per item on the req_ channel; req_file_start marks
// the first byte of each file and restarts parsing. The first HDR_BYTES bytes
// (54 by default) are skipped, then the low bit of each byte is collected, most
// significant bit first: the magic characters, a 32-bit extension length,
// the extension bytes, a 32-bit payload length and the payload bytes.
// Each decoded byte leaves as one item on the rsp_ channel (kind extension or
// payload); a magic mismatch or an empty payload leaves as a status item.
// An accepted item is held in the input register; when it moves on, its
// result, if it has one, is registered in the output register.
// Throughput: one item per cycle while rsp_ready stays high; the parsing
// logic between the two registers is combinational.
// When the receiver stalls, the result waits in the output register and one
// more item is held in the input register before req_ready drops.
// Reset clears both registers, returns parsing to the header skip and sets
// the magic to zero with a length of one character.
// The user writes configuration over the csr_ port only while no item is in flight; the block does not enforce this.
`include "lsb_stego_bmp_extractor_core_defines.svh"
module lsb_stego_bmp_extractor_core import lsbx_pkg::*; #(
   parameter int HDR_BYTES   = HEADER_BYTES,
   parameter int MAGIC_CHARS = MAGIC_MAX
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_image_byte,
   input  logic                  req_file_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type              cfg;
   res_type              res;
   logic                 s1_valid_ff, s1_valid_in;
   logic [CHAR_BITS-1:0] s1_byte_ff;
   logic                 s1_start_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0] rsp_byte_ff;
   kind_type             rsp_kind_ff;
   logic                 rsp_last_ff;
   logic                 advance;
   logic                 req_accept;

   lsbx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lsbx_parser #(
      .HDR_BYTES   (HDR_BYTES),
      .MAGIC_CHARS (MAGIC_CHARS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .image_byte (s1_byte_ff),
      .file_start (s1_start_ff),
      .cfg        (cfg),
      .res        (res)
   );

   // The held item moves on once the output register is free or being emptied.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res.valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff  <= req_image_byte;
         s1_start_ff <= req_file_start;
      end
      if (advance) begin
         rsp_byte_ff <= res.out_byte;
         rsp_kind_ff <= res.kind;
         rsp_last_ff <= res.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_last     = rsp_last_ff;

   `LSBX_ASSERT_NEXT(a_stage_holds, clock, reset,
      s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_start_ff))
   `LSBX_ASSERT_ALWAYS(a_no_overwrite, clock, reset,
      rsp_valid_ff && !rsp_ready, !advance)
   `LSBX_ASSERT_NEXT(a_rsp_holds, clock, reset,
      rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_byte_ff) && $stable(rsp_kind_ff) && $stable(rsp_last_ff))

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the LSB stego BMP extractor: framed files in, decoded bytes out.
module tb import lsbx_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF       = 4;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_MAX     = 10;
   localparam int ITEMS_PER_MODE = 400;

   typedef struct packed {
      logic [7:0] raw;
      logic       start;
   } file_byte_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } extracted_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_image_byte = '0;
   logic                  req_file_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic [1:0]            rsp_kind;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lsb_stego_bmp_extractor_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_image_byte (req_image_byte),
      .req_file_start (req_file_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #CLK_HALF clock = ~clock;

   // Configuration copy and parser state of the predictor.
   logic [MAGIC_W-1:0]     cfg_magic = '0;
   logic [MAGIC_LEN_W-1:0] cfg_len = 4'd1;
   phase_type              st_phase = PH_HEADER;
   logic [COUNT_W-1:0]     st_count = '0;
   logic [31:0]            st_bits = '0;
   logic [3:0]             st_midx = '0;
   logic [REMAIN_W-1:0]    st_remain = '0;
   logic                   st_bad = 1'b0;

   file_byte_type file_bytes_q[$];
   extracted_type expected_bytes_q[$];

   int send_idle_pct = 23;
   int recv_idle_pct = 77;
   int file_budget = 0;
   int bytes_queued = 0;
   int bytes_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int cfg_writes = 0;
   int files_built = 0;
   int idle_cycles = 0;

   // Advances the parser by one file byte; returns 1 when a result comes out.
   function automatic bit extract_step(input logic [7:0] raw, input logic start,
                                       output extracted_type res);
      logic       bit_in;
      logic [3:0] eff;
      logic [7:0] want;
      logic [7:0] ch;
      bit_in = raw[0];
      res = '{data: 8'h00, kind: KIND_EXT, last: 1'b0};
      eff = (cfg_len > 4'(MAGIC_MAX)) ? 4'(MAGIC_MAX) : cfg_len;
      if (start) begin
         st_phase = PH_HEADER;
         st_count = '0;
         st_bits = '0;
         st_midx = '0;
         st_remain = '0;
         st_bad = 1'b0;
      end
      if (st_phase == PH_HEADER) begin
         if (st_remain < HEADER_BYTES) begin
            st_remain++;
            return 1'b0;
         end
         st_remain = '0;
         st_count = '0;
         st_bits = '0;
         st_midx = '0;
         st_bad = 1'b0;
         st_phase = PH_MAGIC;
         // With no magic characters this byte is already the first length bit.
         if (eff == 0) st_phase = PH_EXT_LEN;
      end
      case (st_phase)
         PH_MAGIC: begin
            st_bits = {24'h0, st_bits[6:0], bit_in};
            st_count++;
            if (st_count < 6'(CHAR_BITS)) return 1'b0;
            want = cfg_magic[st_midx[2:0]*8 +: 8];
            if (want != st_bits[7:0]) st_bad = 1'b1;
            st_count = '0;
            st_bits = '0;
            st_midx++;
            if (st_midx >= eff) begin
               if (st_bad) begin
                  st_phase = PH_IDLE;
                  res = '{data: 8'h00, kind: KIND_ERR, last: 1'b1};
                  return 1'b1;
               end
               st_phase = PH_EXT_LEN;
            end
            return 1'b0;
         end
         PH_EXT_LEN, PH_PAY_LEN: begin
            st_bits = {st_bits[30:0], bit_in};
            st_count++;
            if (st_count < 6'(LENGTH_BITS)) return 1'b0;
            st_remain = st_bits[31] ? '0 : st_bits[30:0];
            st_count = '0;
            st_bits = '0;
            if (st_phase == PH_EXT_LEN) begin
               st_phase = (st_remain != 0) ? PH_EXT_DATA : PH_PAY_LEN;
               return 1'b0;
            end
            if (st_remain == 0) begin
               st_phase = PH_IDLE;
               res = '{data: 8'h00, kind: KIND_EMPTY, last: 1'b1};
               return 1'b1;
            end
            st_phase = PH_PAY_DATA;
            return 1'b0;
         end
         PH_EXT_DATA, PH_PAY_DATA: begin
            st_bits = {24'h0, st_bits[6:0], bit_in};
            st_count++;
            if (st_count < 6'(CHAR_BITS)) return 1'b0;
            ch = st_bits[7:0];
            st_count = '0;
            st_bits = '0;
            if (st_remain > 0) st_remain--;
            if (st_phase == PH_EXT_DATA) begin
               if (st_remain == 0) st_phase = PH_PAY_LEN;
               res = '{data: ch, kind: KIND_EXT, last: 1'b0};
               return 1'b1;
            end
            if (st_remain == 0) begin
               st_phase = PH_IDLE;
               res = '{data: ch, kind: KIND_PAY, last: 1'b1};
            end else begin
               res = '{data: ch, kind: KIND_PAY, last: 1'b0};
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input extracted_type want);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s: got byte %02h kind %0d last %0b, expected byte %02h kind %0d last %0b",
                  $realtime, what, rsp_out_byte, rsp_kind, rsp_last,
                  want.data, want.kind, want.last);
   endtask

   // Sender: takes file bytes from the queue and predicts on every accepted item.
   always @(posedge clock) begin : drive_req
      file_byte_type nxt;
      extracted_type res;
      if (reset) begin
         req_valid <= 1'b0;
         req_image_byte <= '0;
         req_file_start <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            bytes_taken++;
            if (extract_step(req_image_byte, req_file_start, res))
               expected_bytes_q.push_back(res);
         end
         if (!req_valid || req_ready) begin
            if (file_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = file_bytes_q.pop_front();
               req_valid <= 1'b1;
               req_image_byte <= nxt.raw;
               req_file_start <= nxt.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure and comparison against the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      extracted_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_bytes_q.size() == 0) begin
               want = '{data: 8'h00, kind: KIND_EXT, last: 1'b0};
               note_mismatch("unexpected result", want);
            end else begin
               want = expected_bytes_q.pop_front();
               if (rsp_out_byte !== want.data || rsp_kind !== want.kind
                   || rsp_last !== want.last)
                  note_mismatch("wrong result", want);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a handshake", idle_cycles);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(int'(idx) * 8);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == CSR_MAGIC_STRING) cfg_magic = val;
      else cfg_len = val[MAGIC_LEN_W-1:0];
      cfg_writes++;
   endtask

   task automatic set_config(input logic [MAGIC_W-1:0] magic, input logic [3:0] len);
      csr_write(CSR_MAGIC_STRING, magic);
      csr_write(CSR_MAGIC_LENGTH, CSR_DATA_W'(len));
   endtask

   // Waits until the block has drained so the registers can be written safely.
   task automatic wait_drained();
      while (file_bytes_q.size() != 0 || req_valid || expected_bytes_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_byte(input logic [7:0] raw, input logic start);
      if (file_budget == 0) return;
      file_budget--;
      file_bytes_q.push_back('{raw: raw, start: start});
      bytes_queued++;
   endtask

   // Hides the low nbits bits of a value in the low bit of each carrier byte, MSB first.
   task automatic add_bits(input logic [31:0] val, input int nbits, input bit plain);
      int         i;
      logic [7:0] raw;
      for (i = nbits - 1; i >= 0; i--) begin
         raw = plain ? {8{val[i]}} : 8'($urandom);
         raw[0] = val[i];
         add_byte(raw, 1'b0);
      end
   endtask

   // Builds one stego file; fill < 0 gives random content, otherwise a fixed byte
   // with carriers that are all zeros or all ones.
   task automatic add_file(input bit lead_start, input bit spoil, input logic [31:0] ext_field,
                           input logic [31:0] pay_field, input int fill, input int budget);
      int         i;
      int         n_chars;
      int         spoil_at;
      int         n_data;
      bit         plain;
      logic [7:0] ch;
      file_budget = budget;
      files_built++;
      plain = (fill >= 0);
      n_chars = (cfg_len > MAGIC_MAX) ? MAGIC_MAX : cfg_len;
      spoil_at = (n_chars == 0) ? 0 : $urandom_range(n_chars - 1);
      for (i = 0; i < HEADER_BYTES; i++)
         add_byte(plain ? 8'(fill) : 8'($urandom), lead_start && i == 0);
      for (i = 0; i < n_chars; i++) begin
         ch = cfg_magic[i*8 +: 8];
         if (spoil && i == spoil_at) ch ^= 8'(1 << $urandom_range(7));
         add_bits(32'(ch), CHAR_BITS, plain);
      end
      add_bits(ext_field, LENGTH_BITS, plain);
      n_data = ext_field[31] ? 0 : ((ext_field > 40) ? 40 : int'(ext_field));
      for (i = 0; i < n_data; i++)
         add_bits(plain ? 32'(fill) : $urandom, CHAR_BITS, plain);
      add_bits(pay_field, LENGTH_BITS, plain);
      n_data = pay_field[31] ? 0 : ((pay_field > 40) ? 40 : int'(pay_field));
      for (i = 0; i < n_data; i++)
         add_bits(plain ? 32'(fill) : $urandom, CHAR_BITS, plain);
      // Bytes after the frame must be ignored until the next file start.
      n_data = $urandom_range(6);
      for (i = 0; i < n_data; i++)
         add_byte(8'($urandom), 1'b0);
   endtask

   function automatic logic [31:0] pick_length(input int top);
      case ($urandom_range(9))
         0: return 32'h0;
         1: return {1'b1, 31'($urandom)};
         2: return 32'h8000_0000 | 32'($urandom_range(top));
         default: return 32'($urandom_range(1, top));
      endcase
   endfunction

   task automatic random_config();
      logic [MAGIC_W-1:0] magic;
      logic [3:0]         len;
      case ($urandom_range(3))
         0: magic = '0;
         1: magic = '1;
         default: magic = {$urandom, $urandom};
      endcase
      case ($urandom_range(5))
         0: len = 4'd0;
         1: len = 4'd1;
         2: len = 4'd8;
         3: len = 4'($urandom_range(9, 15));
         default: len = 4'($urandom_range(1, 8));
      endcase
      set_config(magic, len);
   endtask

   task automatic add_random_unit();
      int i;
      int n;
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         add_file(1'b1, $urandom_range(99) < 15, pick_length(4), pick_length(6), -1, 1 << 30);
      end else if (pick < 85) begin
         // A file cut short by the next file start.
         add_file(1'b1, $urandom_range(1) != 0, pick_length(6), pick_length(6), -1,
                  $urandom_range(1, 200));
      end else begin
         file_budget = 1 << 30;
         n = $urandom_range(10, 80);
         for (i = 0; i < n; i++)
            add_byte(8'($urandom), $urandom_range(99) < 3);
      end
   endtask

   initial begin : run
      int mode;
      int leftover;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (mode = 0; mode < 3; mode++) begin
         wait_drained();
         case (mode)
            0: begin send_idle_pct = 23; recv_idle_pct = 77; end
            1: begin send_idle_pct = 77; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (mode == 0) begin
            // Reset configuration: no file start on the very first file, all-ones
            // content, a magic error, and a file cut short with all-zeros content.
            add_file(1'b0, 1'b0, 32'd2, 32'd3, 8'hFF, 1 << 30);
            add_file(1'b1, 1'b1, 32'd0, 32'd2, -1, HEADER_BYTES + 8 + 4);
            add_file(1'b1, 1'b0, 32'h7FFF_FFFF, 32'd0, 8'h00, HEADER_BYTES + 8 + 32 + 24);
         end else if (mode == 1) begin
            // No magic at all with a payload length that has the sign bit set.
            set_config({$urandom, $urandom}, 4'd0);
            add_file(1'b1, 1'b0, 32'd1, 32'h8000_0004, -1, 1 << 30);
            wait_drained();
            // Lengths above the maximum are clamped to eight characters.
            set_config('0, 4'd15);
            add_file(1'b1, 1'b0, 32'hFFFF_FFFF, 32'd2, -1, 1 << 30);
            wait_drained();
            set_config({$urandom, $urandom}, 4'd9);
            add_file(1'b1, 1'b1, 32'd2, 32'd2, -1, HEADER_BYTES + 64 + 4);
         end
         while (bytes_queued < (mode + 1) * ITEMS_PER_MODE) begin
            wait_drained();
            random_config();
            add_random_unit();
         end
      end

      wait_drained();
      leftover = expected_bytes_q.size();
      if (leftover != 0) $display("%0d predicted results never arrived", leftover);
      $display("Parsed %0d file bytes from %0d files under %0d register writes,",
               bytes_taken, files_built, cfg_writes);
      $display("checked %0d decoded bytes and status results, %0d mismatching.",
               results_seen, mismatches);
      if (mismatches == 0 && leftover == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
